// ===== rtl/lis_length_stream_macros.svh =====
// Assertion macros for the LIS length stream block.
`ifndef LIS_LENGTH_STREAM_MACROS_SVH
`define LIS_LENGTH_STREAM_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LLS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define LLS_ASSERT(lbl, prop, msg)
`define LLS_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/lls_pkg.sv =====
// Shared types and constants of the LIS length stream block.
`default_nettype none
package lls_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned LEN_OUT_W = 11;

  typedef struct packed {
    logic                 final_res;
    logic                 overflow;
    logic [LEN_OUT_W-1:0] length;
  } lls_result_t;

endpackage
`default_nettype wire

// ===== rtl/lls_tail_ram.sv =====
// Tail store: single-port synchronous memory with registered read data.
`default_nettype none
module lls_tail_ram #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire                                   clk_i,
  input  wire                                   we_i,
  input  wire                                   re_i,
  input  wire        [AW-1:0]                   addr_i,
  input  wire signed [lls_pkg::VALUE_W-1:0]     wdata_i,
  output logic signed [lls_pkg::VALUE_W-1:0]    rdata_o
);
  import lls_pkg::*;

  logic signed [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lls_ctrl.sv =====
// Sequencer: classifies each value, runs the binary search and updates the tail store.
`default_nettype none
module lls_ctrl #(
  parameter int unsigned MAX_LEN = 1024,
  localparam int unsigned AW = $clog2(MAX_LEN),
  localparam int unsigned LW = $clog2(MAX_LEN + 1)
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                req_valid_i,
  output logic                               req_ready_o,
  input  wire signed [lls_pkg::VALUE_W-1:0]  value_i,
  input  wire                                first_i,
  input  wire                                last_i,
  input  wire signed [lls_pkg::VALUE_W-1:0]  rdata_i,
  output logic                               mem_we_o,
  output logic                               mem_re_o,
  output logic       [AW-1:0]                mem_addr_o,
  output logic signed [lls_pkg::VALUE_W-1:0] mem_wdata_o,
  output logic                               res_valid_o,
  input  wire                                res_ready_i,
  output lls_pkg::lls_result_t               res_o,
  output logic       [LW-1:0]                len_o
);
  import lls_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SEARCH,
    ST_EMIT
  } state_e;

  state_e                    state_q, state_d;
  logic signed [VALUE_W-1:0] val_q, val_d;
  logic signed [VALUE_W-1:0] head_q, head_d;
  logic signed [VALUE_W-1:0] tail_q, tail_d;
  logic                      first_q, first_d;
  logic                      last_q, last_d;
  logic                      ovf_q, ovf_d;
  logic [LW-1:0]             len_q, len_d;
  logic [AW-1:0]             lo_q, lo_d;
  logic [AW-1:0]             hi_q, hi_d;
  logic [AW-1:0]             mid_q, mid_d;

  logic [AW-1:0]             hi_init;
  logic [AW-1:0]             lo_n;
  logic [AW-1:0]             hi_n;
  logic [AW-1:0]             mid_n;
  logic [AW-1:0]             last_idx;
  logic [LW+LEN_OUT_W-1:0]   len_ext;

  assign last_idx = AW'(len_q - LW'(1));
  assign hi_init  = last_idx;

  // One search step: narrow the window by the tail read in the previous cycle.
  assign lo_n  = (rdata_i < val_q) ? (mid_q + AW'(1)) : lo_q;
  assign hi_n  = (rdata_i < val_q) ? hi_q : mid_q;
  assign mid_n = lo_n + ((hi_n - lo_n) >> 1);

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    head_d      = head_q;
    tail_d      = tail_q;
    first_d     = first_q;
    last_d      = last_q;
    ovf_d       = ovf_q;
    len_d       = len_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_addr_o  = '0;
    mem_wdata_o = val_q;

    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          val_d   = value_i;
          first_d = first_i;
          last_d  = last_i;
          ovf_d   = 1'b0;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_EMIT;
        if (first_q || (len_q == '0)) begin
          mem_we_o = 1'b1;
          head_d   = val_q;
          tail_d   = val_q;
          len_d    = LW'(1);
        end else if (val_q < head_q) begin
          mem_we_o = 1'b1;
          head_d   = val_q;
          if (len_q == LW'(1)) begin
            tail_d = val_q;
          end
        end else if (val_q > tail_q) begin
          if (len_q < LW'(MAX_LEN)) begin
            mem_we_o   = 1'b1;
            mem_addr_o = len_q[AW-1:0];
            tail_d     = val_q;
            len_d      = len_q + LW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end else if (hi_init != '0) begin
          // Value lies within the tails: search for the first tail not below it.
          lo_d       = '0;
          hi_d       = hi_init;
          mid_d      = hi_init >> 1;
          mem_re_o   = 1'b1;
          mem_addr_o = hi_init >> 1;
          state_d    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (lo_n < hi_n) begin
          lo_d       = lo_n;
          hi_d       = hi_n;
          mid_d      = mid_n;
          mem_re_o   = 1'b1;
          mem_addr_o = mid_n;
        end else begin
          // The found tail is not below the value; rewriting an equal tail is harmless.
          mem_we_o   = 1'b1;
          mem_addr_o = lo_n;
          if (lo_n == last_idx) begin
            tail_d = val_q;
          end
          if (lo_n == '0) begin
            head_d = val_q;
          end
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    head_q  <= head_d;
    tail_q  <= tail_d;
    first_q <= first_d;
    last_q  <= last_d;
    ovf_q   <= ovf_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
  end

  assign len_ext          = (LW + LEN_OUT_W)'(len_q);
  assign req_ready_o      = (state_q == ST_IDLE);
  assign res_valid_o      = (state_q == ST_EMIT);
  assign res_o.length     = len_ext[LEN_OUT_W-1:0];
  assign res_o.overflow   = ovf_q;
  assign res_o.final_res  = last_q;
  assign len_o            = len_q;

endmodule
`default_nettype wire

// ===== rtl/lis_length_stream.sv =====
// Top level of the streaming longest-increasing-subsequence length block.
// Each accepted request passes the classification state, then, for a value within
// the tails, a binary search of k tail reads (0 for a new sequence, a new head or
// an append; at most ceil(log2(length)), 10 for 1024 tails), then the result state.
// A new request is taken only once the sequencer is idle again after the handover.
// Reset clears the length and the handshake state; the tail store is not cleared.
`default_nettype none
`include "lis_length_stream_macros.svh"
module lis_length_stream #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [31:0] s_axis_tdata,   // [31:0] value (signed)
  input  wire  [0:0]  s_axis_tuser,   // [0] first_item
  input  wire         s_axis_tlast,   // last_item
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [10:0] length, [15:11] zero
  output logic [0:0]  m_axis_tuser,   // [0] overflow
  output logic        m_axis_tlast    // final_res
);
  import lls_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam logic [LEN_OUT_W-1:0] LEN_FULL = LEN_OUT_W'(MAX_LEN);

  // Interface between the sequencer and the tail store.
  logic                      mem_we;
  logic                      mem_re;
  logic [AW-1:0]             mem_addr;
  logic signed [VALUE_W-1:0] mem_wdata;
  logic signed [VALUE_W-1:0] mem_rdata;

  // Result hand-over from the sequencer to the output register.
  logic                      res_valid;
  logic                      res_ready;
  lls_result_t               res;
  logic [LW-1:0]             cur_len;

  logic                      out_valid_q, out_valid_d;
  lls_result_t               out_q, out_d;

  // The sequencer owns the classification of each value (new sequence, new head,
  // append, overflow or search) and the binary search itself. It holds copies of
  // the first and last tails so that only the search reads the memory.
  lls_ctrl #(
    .MAX_LEN (MAX_LEN)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .value_i     (s_axis_tdata),
    .first_i     (s_axis_tuser[0]),
    .last_i      (s_axis_tlast),
    .rdata_i     (mem_rdata),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .len_o       (cur_len)
  );

  // Tail store: one entry per subsequence length, with registered read data.
  lls_tail_ram #(
    .DEPTH (MAX_LEN)
  ) u_tail_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // The output register frees the sequencer as soon as a result is handed over,
  // so the next request can be taken while the downstream side still stalls.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = {5'b00000, out_q.length};
  assign m_axis_tuser[0] = out_q.overflow;
  assign m_axis_tlast    = out_q.final_res;

  // The single memory port never reads and writes in the same cycle.
  `LLS_ASSERT(a_port_excl, !(mem_we && mem_re), "tail store read and written together")
  // The search only ever reads tails that belong to the current sequence.
  `LLS_ASSERT_IMP(a_read_in_range, mem_re, LW'(mem_addr) < cur_len, "read beyond length")
  // An overflow is only reported with the store full.
  `LLS_ASSERT_IMP(a_ovf_full, m_axis_tvalid && m_axis_tuser[0],
                  m_axis_tdata[10:0] == LEN_FULL, "overflow below capacity")

endmodule
`default_nettype wire

// ===== tb/tb_lis_length_stream.sv =====
// Self-checking testbench for the streaming longest-increasing-subsequence length block.
`timescale 1ns / 100ps
module tb_lis_length_stream;
  import lls_pkg::*;

  localparam int unsigned MAX_LEN     = 1024;
  localparam int unsigned ITEM_TARGET = 1900;
  localparam int unsigned CALM_FROM   = 1700;  // no idling on either side after this
  localparam int unsigned FILL_AT     = 300;   // the store is filled to the brim here
  localparam int unsigned HOLD_CYCLES = 400;   // long output stall to back up the input
  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned SETTLE      = 32;    // idle time after the last result before the final check
  localparam logic [31:0] MOST_NEG    = 32'h8000_0000;
  localparam logic [31:0] MOST_POS    = 32'h7FFF_FFFF;

  typedef enum int {STYLE_WIDE, STYLE_NARROW, STYLE_RISING, STYLE_FALLING} value_style_e;

  // Tracks the tails of the current sequence and the lengths the block must report.
  class lis_tracker #(int unsigned DEPTH = 1024);
    logic signed [31:0]  tails [DEPTH];
    int unsigned         run_length;
    lls_pkg::lls_result_t expected_q[$];
    int unsigned         results_seen;
    int unsigned         errors;

    function new();
      run_length   = 0;
      results_seen = 0;
      errors       = 0;
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function void note_request(logic signed [31:0] value, bit first, bit last);
      lls_pkg::lls_result_t res;
      int unsigned k;
      res.overflow = 1'b0;
      if (first || run_length == 0) begin
        tails[0]   = value;
        run_length = 1;
      end else if (value > tails[run_length-1]) begin
        if (run_length < DEPTH) begin
          tails[run_length] = value;
          run_length++;
        end else begin
          res.overflow = 1'b1;
        end
      end else begin
        // First tail not below the value; an equal tail is rewritten unchanged.
        k = 0;
        while (tails[k] < value) k++;
        tails[k] = value;
      end
      res.length    = run_length[lls_pkg::LEN_OUT_W-1:0];
      res.final_res = last;
      expected_q = {expected_q, res};
    endfunction

    task check_result(logic [15:0] data, logic overflow, logic final_res);
      lls_pkg::lls_result_t exp_res;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result with no request waiting, length %0d", data[10:0]));
      end else begin
        exp_res = expected_q.pop_front();
        if (data[10:0] !== exp_res.length)
          report($sformatf("length %0d, expected %0d", data[10:0], exp_res.length));
        if (data[15:11] !== 5'd0)
          report($sformatf("padding bits %b not zero", data[15:11]));
        if (overflow !== exp_res.overflow)
          report($sformatf("overflow %b, expected %b", overflow, exp_res.overflow));
        if (final_res !== exp_res.final_res)
          report($sformatf("last flag %b, expected %b", final_res, exp_res.final_res));
      end
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task close();
      if (expected_q.size() != 0)
        report($sformatf("%0d results never arrived", expected_q.size()));
    endtask
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;

  lis_tracker #(.DEPTH(MAX_LEN)) board;
  int unsigned requests_sent = 0;
  bit          calm          = 1'b0;

  lis_length_stream #(.MAX_LEN(MAX_LEN)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  // Offers one request, sometimes after a short gap; valid stays high between
  // back-to-back requests so it is never dropped and raised in one step.
  task automatic send_request(input logic [31:0] value, input bit first, input bit last);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request($signed(value), first, last);
    requests_sent++;
    if (requests_sent >= CALM_FROM) calm = 1'b1;
  endtask

  // A sequence with a head flag on its first request and a last flag on its
  // final one, now and then broken by a missing head or stray flags.
  task automatic send_sequence(input int count, input value_style_e style);
    logic [31:0] v;
    bit          first;
    bit          last;
    longint      walk;
    walk = longint'($signed($urandom));
    for (int i = 0; i < count; i++) begin
      case (style)
        STYLE_WIDE:   v = $urandom;
        STYLE_NARROW: v = 32'($urandom_range(0, 16)) - 32'd8;
        STYLE_RISING: begin
          walk += longint'($urandom_range(0, 40)) - 8;
          v = walk[31:0];
        end
        default: begin
          walk -= longint'($urandom_range(0, 40)) - 8;
          v = walk[31:0];
        end
      endcase
      first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
      last  = (i == count - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
      send_request(v, first, last);
    end
  endtask

  // Strictly rising values beyond the store depth, so appends are dropped,
  // then random values that search the full store or overflow again.
  task automatic send_fill();
    longint walk;
    walk = -64'sd2147483648 + longint'($urandom_range(0, 1000));
    for (int i = 0; i < MAX_LEN + 6; i++) begin
      send_request(walk[31:0], i == 0, 1'b0);
      walk += longint'($urandom_range(1, 2000000));
    end
    for (int i = 0; i < 12; i++) send_request($urandom, 1'b0, i == 11);
  endtask

  initial begin : request_side
    bit fill_done;
    fill_done = 1'b0;
    board = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A value with no head flag straight after reset still opens a sequence.
    send_request(32'd5, 1'b0, 1'b0);
    send_request(MOST_NEG, 1'b1, 1'b0);
    send_request(MOST_POS, 1'b0, 1'b0);       // append after the most negative head
    send_request(MOST_NEG, 1'b0, 1'b0);       // equal to the head: no change
    send_request(32'd0, 1'b0, 1'b0);          // replaces the top tail
    send_request(32'd0, 1'b0, 1'b0);          // equal to a tail
    send_request(32'd10, 1'b0, 1'b0);
    send_request(32'hFFFF_FFFB, 1'b0, 1'b0);  // -5 lands on the middle tail
    send_request(32'd7, 1'b0, 1'b0);
    send_request(32'd7, 1'b0, 1'b1);
    send_request(32'd100, 1'b1, 1'b0);        // restart mid-stream
    send_request(32'd50, 1'b0, 1'b0);         // below the head
    send_request(32'd60, 1'b0, 1'b0);
    send_request(32'd55, 1'b0, 1'b0);
    send_request(32'd70, 1'b0, 1'b0);
    send_request(32'd80, 1'b0, 1'b0);
    send_request(32'd90, 1'b0, 1'b0);
    send_request(32'd75, 1'b0, 1'b0);         // search over five tails
    send_request(MOST_POS, 1'b0, 1'b1);
    send_request(32'hFFFF_FFFF, 1'b1, 1'b1);  // one-request sequence
    send_request(MOST_NEG, 1'b0, 1'b0);

    while (requests_sent < ITEM_TARGET) begin
      if (!fill_done && requests_sent >= FILL_AT) begin
        send_fill();
        fill_done = 1'b1;
      end else begin
        send_sequence($urandom_range(1, 40), value_style_e'($urandom_range(0, 3)));
      end
    end
    s_axis_tvalid <= 1'b0;

    for (int w = 0; w < DRAIN_LIMIT && board.pending() != 0; w++) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    board.close();
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Output side: random stall bursts, one long hold so the input backs up,
  // and none at all once the run has gone calm.
  initial begin : result_side
    int unsigned stall_left;
    bit          held;
    stall_left = 0;
    held       = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        board.check_result(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
      if (stall_left > 0) begin
        stall_left--;
      end else if (!held && board.results_seen >= 150) begin
        stall_left = HOLD_CYCLES;
        held       = 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 8);
      end
      m_axis_tready <= (stall_left == 0);
    end
  end

  initial begin : watchdog
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lls_pkg.sv
rtl/lls_tail_ram.sv
rtl/lls_ctrl.sv
rtl/lis_length_stream.sv
tb/tb_lis_length_stream.sv
